// ===== src/cascaded_biquad_filter_macros.svh =====
// ----------------------------------------------------------------------------
// cascaded_biquad_filter assertion macros
// Shorthand for clocked, reset-qualified checks used in the filter RTL.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_FILTER_MACROS_SVH

// same-cycle implication
`define CBQF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBQF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cbqf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbqf_pkg
// Shared types and constants of the cascaded biquad filter.
// ----------------------------------------------------------------------------
package cbqf_pkg;

    localparam int COEF_W        = 24;
    localparam int SAMPLE_W      = 24;
    localparam int STATE_W       = 32;
    localparam int COEFS_PER_SEC = 6;
    localparam int A_BASE        = 3;

    // command codes
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // coefficient slots within a section
    localparam logic [2:0] IDX_B0 = 3'd0;
    localparam logic [2:0] IDX_B1 = 3'd1;
    localparam logic [2:0] IDX_B2 = 3'd2;
    localparam logic [2:0] IDX_A1 = 3'(A_BASE + 1);
    localparam logic [2:0] IDX_A2 = 3'(A_BASE + 2);

    // multiplier operand select
    localparam logic [1:0] OPND_DELAY = 2'd0;
    localparam logic [1:0] OPND_W1    = 2'd1;
    localparam logic [1:0] OPND_W2    = 2'd2;
    localparam logic [1:0] OPND_W     = 2'd3;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD = 3'd0;
    localparam logic [2:0] ACC_INIT = 3'd1;
    localparam logic [2:0] ACC_SUB  = 3'd2;
    localparam logic [2:0] ACC_ADD  = 3'd3;
    localparam logic [2:0] ACC_LOAD = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       load_w1;
        logic       load_w2;
        logic [1:0] opnd;
        logic [2:0] acc_op;
        logic       round_w;
        logic       round_x;
    } t_mac_ctl;

endpackage

// ===== src/cbqf_ram.sv =====
// ----------------------------------------------------------------------------
// cbqf_ram
// One-write, one-read synchronous RAM with registered read data. A per-entry
// valid bit makes never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module cbqf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== src/cbqf_mac.sv =====
// ----------------------------------------------------------------------------
// cbqf_mac
// Shared 24x32 multiplier with registered product, 58-bit accumulator,
// round/saturate logic and the per-section working registers.
// ----------------------------------------------------------------------------
module cbqf_mac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cbqf_pkg::t_mac_ctl       i_ctl,
    input  logic signed [23:0]       i_sample,
    input  logic signed [23:0]       i_coef,
    input  logic signed [31:0]       i_delay,
    output logic signed [31:0]       o_w1,
    output logic signed [31:0]       o_w,
    output logic signed [23:0]       o_final_sample,
    output logic                     o_final_clip
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_w1;
    logic signed [31:0] r_w2;
    logic signed [31:0] r_w;
    logic signed [55:0] r_prod;
    logic signed [57:0] r_acc;
    logic               r_clip;

    logic signed [31:0] opnd;
    logic signed [55:0] mul;
    logic signed [57:0] prod_ext;
    logic signed [57:0] rnd_sum;
    logic        [35:0] rnd_shr;
    logic signed [31:0] rnd_val;
    logic               rnd_clip;
    logic               sat24_clip;

    always_comb begin
        case (i_ctl.opnd)
            cbqf_pkg::OPND_DELAY: opnd = i_delay;
            cbqf_pkg::OPND_W1:    opnd = r_w1;
            cbqf_pkg::OPND_W2:    opnd = r_w2;
            default:              opnd = r_w;
        endcase
    end

    assign mul      = i_coef * opnd;
    assign prod_ext = {{2{r_prod[55]}}, r_prod};

    // round half up, dropping 22 fraction bits, then clamp to 32 bits
    assign rnd_sum = r_acc + 58'sd2097152;
    assign rnd_shr = rnd_sum[57:22];

    always_comb begin
        if ((&rnd_shr[35:31]) || !(|rnd_shr[35:31])) begin
            rnd_val  = rnd_shr[31:0];
            rnd_clip = 1'b0;
        end else begin
            rnd_val  = rnd_shr[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            rnd_clip = 1'b1;
        end
    end

    always_comb begin
        if ((&rnd_val[31:23]) || !(|rnd_val[31:23])) begin
            o_final_sample = rnd_val[23:0];
            sat24_clip     = 1'b0;
        end else begin
            o_final_sample = rnd_val[31] ? 24'sh80_0000 : 24'sh7f_ffff;
            sat24_clip     = 1'b1;
        end
    end

    assign o_final_clip = r_clip | rnd_clip | sat24_clip;
    assign o_w1         = r_w1;
    assign o_w          = r_w;

    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        if (i_ctl.capture) begin
            r_x <= {{8{i_sample[23]}}, i_sample};
        end else if (i_ctl.round_x) begin
            r_x <= rnd_val;
        end
        if (i_ctl.load_w1) begin
            r_w1 <= i_delay;
        end
        if (i_ctl.load_w2) begin
            r_w2 <= i_delay;
        end
        if (i_ctl.round_w) begin
            r_w <= rnd_val;
        end
        case (i_ctl.acc_op)
            cbqf_pkg::ACC_INIT: r_acc <= {{4{r_x[31]}}, r_x, 22'b0};
            cbqf_pkg::ACC_SUB:  r_acc <= r_acc - prod_ext;
            cbqf_pkg::ACC_ADD:  r_acc <= r_acc + prod_ext;
            cbqf_pkg::ACC_LOAD: r_acc <= prod_ext;
            default:            r_acc <= r_acc;
        endcase
    end

    // sticky saturation flag for the sample in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else if (i_ctl.capture) begin
            r_clip <= 1'b0;
        end else if ((i_ctl.round_w || i_ctl.round_x) && rnd_clip) begin
            r_clip <= 1'b1;
        end
    end

endmodule

// ===== src/cascaded_biquad_filter.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_filter
// Cascade of direct-form-II biquad sections sharing one multiplier.
// ----------------------------------------------------------------------------
// A coefficient write (cmd=1) is taken while idle and gives no result. A
// sample (cmd=0) runs through sections 0..N-1, N being sections_in_use clamped
// to 1..MAX_SECTIONS. It holds the input off until its last section is done,
// so no new item is taken before the sample is through. Each section makes
// five passes through the single 24x32 multiplier, fed by the one read port
// of the coefficient RAM, with the taps read from and written back to the
// delay RAM. The result sits in an output register, so a new item is taken
// while it waits; a finished sample only stalls when the previous result is
// still untaken. Both RAMs read as zero after reset.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_filter_macros.svh"

module cascaded_biquad_filter #(
    parameter int MAX_SECTIONS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic signed [23:0] i_sample_in,
    input  logic               i_last_in_buffer,
    input  logic [1:0]         i_coef_section,
    input  logic [2:0]         i_coef_index,
    input  logic signed [23:0] i_coef_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_sample_out,
    output logic               o_clipped,
    output logic               o_last_out
);

    localparam int NUM_COEFS = MAX_SECTIONS * cbqf_pkg::COEFS_PER_SEC;
    localparam int NUM_TAPS  = MAX_SECTIONS * 2;
    localparam int CAW       = $clog2(NUM_COEFS);
    localparam int DAW       = $clog2(NUM_TAPS);
    localparam int SW        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CWW       = (CAW > 5) ? CAW : 5;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_MUL_A1 = 3'd1;
    localparam logic [2:0] S_MUL_A2 = 3'd2;
    localparam logic [2:0] S_MUL_B1 = 3'd3;
    localparam logic [2:0] S_RND_W  = 3'd4;
    localparam logic [2:0] S_MUL_B0 = 3'd5;
    localparam logic [2:0] S_ACC_B0 = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic           r_state;
    logic [2:0]     r_step;
    logic [SW-1:0]  r_sec;
    logic [SW-1:0]  r_last_sec;
    logic [CAW-1:0] r_coef_base;
    logic [2:0]     r_sections;
    logic           r_last;
    logic           r_out_valid;
    logic [23:0]    r_sample_out;
    logic           r_clipped;
    logic           r_last_out;

    logic               in_fire;
    logic               out_free;
    logic               final_go;
    logic [SW-1:0]      n_last_sec;
    logic [4:0]         cnt5;
    logic [4:0]         max5;
    logic [4:0]         last5;
    logic [CWW-1:0]     cw_sum;
    logic               coef_we;
    logic [CAW-1:0]     coef_waddr;
    logic [CAW-1:0]     coef_raddr;
    logic signed [23:0] coef_rdata;
    logic [SW:0]        dly_base_w;
    logic [DAW-1:0]     dly_base;
    logic               dly_we;
    logic [DAW-1:0]     dly_waddr;
    logic [31:0]        dly_wdata;
    logic [DAW-1:0]     dly_raddr;
    logic signed [31:0] dly_rdata;
    logic signed [31:0] mac_w1;
    logic signed [31:0] mac_w;
    logic signed [23:0] final_sample;
    logic               final_clip;
    cbqf_pkg::t_mac_ctl ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign final_go   = (r_state == ST_RUN) && (r_step == S_DONE) &&
                        (r_sec == r_last_sec) && out_free;

    // clamp the section count to 1..MAX_SECTIONS
    assign cnt5 = {2'b0, r_sections};
    assign max5 = 5'(MAX_SECTIONS);
    always_comb begin
        if (cnt5 == 5'd0) begin
            last5 = 5'd0;
        end else if (cnt5 > max5) begin
            last5 = max5 - 5'd1;
        end else begin
            last5 = cnt5 - 5'd1;
        end
    end
    assign n_last_sec = last5[SW-1:0];

    // coefficient write: out-of-range section or slot is dropped
    assign cw_sum     = CWW'(i_coef_section) * CWW'(cbqf_pkg::COEFS_PER_SEC)
                      + CWW'(i_coef_index);
    assign coef_waddr = cw_sum[CAW-1:0];
    assign coef_we    = in_fire && (i_cmd == cbqf_pkg::CMD_COEF) &&
                        (CWW'(i_coef_section) < CWW'(MAX_SECTIONS)) &&
                        (i_coef_index < 3'(cbqf_pkg::COEFS_PER_SEC));

    assign dly_base_w = {r_sec, 1'b0};
    assign dly_base   = dly_base_w[DAW-1:0];

    // per-step schedule: each RAM read is issued in the step before the one that uses its data
    always_comb begin
        ctl         = '0;
        ctl.opnd    = cbqf_pkg::OPND_DELAY;
        ctl.acc_op  = cbqf_pkg::ACC_HOLD;
        ctl.capture = in_fire && (i_cmd == cbqf_pkg::CMD_FILTER);
        coef_raddr  = r_coef_base;
        dly_raddr   = dly_base;
        dly_we      = 1'b0;
        dly_waddr   = dly_base;
        dly_wdata   = mac_w;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                S_INIT: begin
                    ctl.acc_op = cbqf_pkg::ACC_INIT;
                    coef_raddr = r_coef_base + CAW'(cbqf_pkg::IDX_A1);
                end
                S_MUL_A1: begin
                    ctl.load_w1 = 1'b1;
                    coef_raddr  = r_coef_base + CAW'(cbqf_pkg::IDX_A2);
                    dly_raddr   = dly_base + DAW'(1);
                end
                S_MUL_A2: begin
                    ctl.load_w2 = 1'b1;
                    ctl.acc_op  = cbqf_pkg::ACC_SUB;
                    coef_raddr  = r_coef_base + CAW'(cbqf_pkg::IDX_B1);
                end
                S_MUL_B1: begin
                    ctl.acc_op = cbqf_pkg::ACC_SUB;
                    ctl.opnd   = cbqf_pkg::OPND_W1;
                    coef_raddr = r_coef_base + CAW'(cbqf_pkg::IDX_B2);
                end
                S_RND_W: begin
                    ctl.round_w = 1'b1;
                    ctl.acc_op  = cbqf_pkg::ACC_LOAD;
                    ctl.opnd    = cbqf_pkg::OPND_W2;
                    coef_raddr  = r_coef_base + CAW'(cbqf_pkg::IDX_B0);
                    // old w1 becomes w2
                    dly_we      = 1'b1;
                    dly_waddr   = dly_base + DAW'(1);
                    dly_wdata   = mac_w1;
                end
                S_MUL_B0: begin
                    ctl.acc_op = cbqf_pkg::ACC_ADD;
                    ctl.opnd   = cbqf_pkg::OPND_W;
                    dly_we     = 1'b1;
                end
                S_ACC_B0: begin
                    ctl.acc_op = cbqf_pkg::ACC_ADD;
                end
                S_DONE: begin
                    ctl.round_x = (r_sec != r_last_sec);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_INIT;
            r_sec       <= '0;
            r_last_sec  <= '0;
            r_coef_base <= '0;
            r_sections  <= 3'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sections <= i_cfg_wdata;
            end
            if (final_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire && (i_cmd == cbqf_pkg::CMD_FILTER)) begin
                        r_state     <= ST_RUN;
                        r_step      <= S_INIT;
                        r_sec       <= '0;
                        r_coef_base <= '0;
                        r_last_sec  <= n_last_sec;
                    end
                end
                ST_RUN: begin
                    if (r_step != S_DONE) begin
                        r_step <= r_step + 3'd1;
                    end else if (r_sec != r_last_sec) begin
                        r_step      <= S_INIT;
                        r_sec       <= r_sec + SW'(1);
                        r_coef_base <= r_coef_base + CAW'(cbqf_pkg::COEFS_PER_SEC);
                    end else if (out_free) begin
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_cmd == cbqf_pkg::CMD_FILTER)) begin
            r_last <= i_last_in_buffer;
        end
        if (final_go) begin
            r_sample_out <= final_sample;
            r_clipped    <= final_clip;
            r_last_out   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;
    assign o_last_out   = r_last_out;

    cbqf_ram #(
        .WIDTH (cbqf_pkg::COEF_W),
        .DEPTH (NUM_COEFS),
        .AW    (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    cbqf_ram #(
        .WIDTH (cbqf_pkg::STATE_W),
        .DEPTH (NUM_TAPS),
        .AW    (DAW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dly_we),
        .i_waddr (dly_waddr),
        .i_wdata (dly_wdata),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    cbqf_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_sample       (i_sample_in),
        .i_coef         (coef_rdata),
        .i_delay        (dly_rdata),
        .o_w1           (mac_w1),
        .o_w            (mac_w),
        .o_final_sample (final_sample),
        .o_final_clip   (final_clip)
    );

    `CBQF_ASSERT_SAME(a_coef_wr_idle, coef_we, r_state == ST_IDLE, "coef write while busy")
    `CBQF_ASSERT_SAME(a_dly_wr_run, dly_we, r_state == ST_RUN && r_sec <= r_last_sec, "stray tap write")
    `CBQF_ASSERT_NEXT(a_start, ctl.capture, r_state == ST_RUN && r_step == S_INIT && r_sec == '0, "sample did not start")
    `CBQF_ASSERT_NEXT(a_result, final_go, o_out_valid && r_state == ST_IDLE, "result not posted")

endmodule
